### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point rotator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/erot_pkg.sv
// ---------------------------------------------------------------------------
// Point rotator package
// Widths, constants and types shared by the rotator modules.
// ---------------------------------------------------------------------------
package erot_pkg;

    localparam int TERM_FRAC_BITS = 16;
    localparam int TERM_W         = TERM_FRAC_BITS + 2;
    localparam int PROD_W         = TERM_W + 1;
    localparam int TERM_ONE       = 1 << TERM_FRAC_BITS;
    localparam int NUM_TERMS      = 9;
    localparam int NUM_PROD       = 14;
    localparam int PI_W           = $clog2(NUM_PROD);

    localparam int COORD_W        = 32;
    localparam int PT_PROD_W      = TERM_W + COORD_W;
    localparam int ACC_W          = PT_PROD_W + 2;
    localparam int RND_W          = ACC_W - TERM_FRAC_BITS;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    localparam int ANGLE_W        = 16;
    localparam int OCT_W          = ANGLE_W - 2;
    localparam int Q_BITS         = 30;
    localparam int MUL_W          = 34;
    localparam int RECIP_SHIFT    = 33;
    localparam logic [MUL_W-1:0] TWO_PI_Q30 = 34'd6746518852;
    localparam logic [Q_BITS:0]  Q30_ONE    = 31'h4000_0000;

    localparam int NUM_DIV        = 7;
    localparam int DIV_W          = 6;
    localparam int K_W            = 3;
    localparam logic [K_W-1:0] SIN_LAST  = 3'd2;
    localparam logic [K_W-1:0] COS_FIRST = 3'd3;
    localparam logic [K_W-1:0] COS_LAST  = 3'd6;
    localparam logic [DIV_W-1:0] DIVISOR [NUM_DIV] =
        '{6'd42, 6'd20, 6'd6, 6'd56, 6'd30, 6'd12, 6'd2};
    localparam logic [MUL_W-1:0] RECIP [NUM_DIV] = '{
        34'((64'd1 << RECIP_SHIFT) / 64'd42),
        34'((64'd1 << RECIP_SHIFT) / 64'd20),
        34'((64'd1 << RECIP_SHIFT) / 64'd6),
        34'((64'd1 << RECIP_SHIFT) / 64'd56),
        34'((64'd1 << RECIP_SHIFT) / 64'd30),
        34'((64'd1 << RECIP_SHIFT) / 64'd12),
        34'((64'd1 << RECIP_SHIFT) / 64'd2)
    };

    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic [NUM_TERMS-1:0][TERM_W-1:0] term_mat_t;

    localparam logic [TERM_W-1:0] TERM_ONE_W  = TERM_W'(TERM_ONE);
    localparam logic [TERM_W-1:0] TERM_ZERO_W = '0;
    localparam term_mat_t TERM_IDENTITY = {TERM_ONE_W, {3{TERM_ZERO_W}}, TERM_ONE_W,
                                           {3{TERM_ZERO_W}}, TERM_ONE_W};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef enum logic [1:0] {
        REG_ANGLE_Z = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_X = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        BLD_IDLE,
        BLD_X,
        BLD_X2,
        BLD_DIVM,
        BLD_DIVF,
        BLD_PMUL,
        BLD_SFIN,
        BLD_PROD,
        BLD_COMB
    } build_state_t;

endpackage

### rtl/erot_if.sv
// ---------------------------------------------------------------------------
// Point rotator channels
// Input point, output point and configuration write channels.
// ---------------------------------------------------------------------------
interface erot_in_if import erot_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface erot_out_if import erot_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      saturated;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output saturated, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input saturated, output ready);
endinterface

interface erot_cfg_if import erot_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         index;
    logic [ANGLE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/erot_terms.sv
// ---------------------------------------------------------------------------
// Rotation term builder
// Holds the angles and rebuilds the nine matrix terms on a shared multiplier.
// ---------------------------------------------------------------------------
module erot_terms import erot_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    erot_cfg_if.sink    cfg,
    output logic        busy,
    output term_mat_t   terms
);

    build_state_t state_reg, state_next;

    logic [ANGLE_W-1:0] angle_reg [3];
    logic [1:0]         ai_reg;
    logic [K_W-1:0]     k_reg;
    logic [PI_W-1:0]    pi_reg;
    term_mat_t          terms_reg;

    logic [Q_BITS-1:0]  x_reg;
    logic [Q_BITS-1:0]  x2_reg;
    logic [Q_BITS-1:0]  v_reg;
    logic [Q_BITS-1:0]  qe_reg;
    logic [Q_BITS:0]    t_reg;
    logic [TERM_W-1:0]  ps_reg;
    term_t              sin_reg [3];
    term_t              cos_reg [3];
    logic signed [PROD_W-1:0] pr_reg [NUM_PROD];

    logic               cfg_fire;
    logic               cfg_is_angle;
    logic [ANGLE_W-1:0] ang;
    logic [1:0]         quad;
    logic [OCT_W-1:0]   rr;
    logic               swap;
    logic [OCT_W-1:0]   oct;

    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod_full;
    logic signed [2*MUL_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0]  pr_new;
    logic signed [PROD_W-1:0]  op_a;
    logic signed [PROD_W-1:0]  op_b;

    logic [Q_BITS+DIV_W-1:0] qd;
    logic [Q_BITS+DIV_W-1:0] rem;
    logic [Q_BITS-1:0]  q;
    logic [Q_BITS:0]    t_new;
    logic [TERM_W-1:0]  pc_new;
    term_t              s_oct;
    term_t              c_oct;
    term_t              s_fin;
    term_t              c_fin;

    function automatic logic [TERM_W-1:0] q30_to_term(input logic [Q_BITS:0] v);
        logic [Q_BITS:0] s;
        s = v + (31'd1 << (Q_BITS - 1 - TERM_FRAC_BITS));
        return TERM_W'(s >> (Q_BITS - TERM_FRAC_BITS));
    endfunction

    function automatic term_t clamp_term(input logic signed [PROD_W:0] v);
        if (v > (PROD_W+1)'(TERM_ONE))
            return TERM_W'(TERM_ONE);
        else if (v < -(PROD_W+1)'(TERM_ONE))
            return -TERM_W'(TERM_ONE);
        else
            return TERM_W'(v);
    endfunction

    assign cfg_fire     = cfg.valid && cfg.ready;
    assign cfg_is_angle = cfg.index inside {REG_ANGLE_Z, REG_ANGLE_Y, REG_ANGLE_X};
    assign cfg.ready    = (state_reg == BLD_IDLE);
    assign busy         = (state_reg != BLD_IDLE);
    assign terms        = terms_reg;

    assign ang  = angle_reg[ai_reg];
    assign quad = ang[ANGLE_W-1 -: 2];
    assign rr   = ang[OCT_W-1:0];
    assign swap = (rr > OCT_W'(1 << (OCT_W - 1)));
    assign oct  = swap ? OCT_W'((OCT_W+1)'(1 << OCT_W) - (OCT_W+1)'(rr)) : rr;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (pi_reg)
            4'd0:    begin op_a = PROD_W'(sin_reg[2]); op_b = PROD_W'(sin_reg[1]); end
            4'd1:    begin op_a = PROD_W'(cos_reg[2]); op_b = PROD_W'(sin_reg[1]); end
            4'd2:    begin op_a = PROD_W'(cos_reg[1]); op_b = PROD_W'(cos_reg[0]); end
            4'd3:    begin op_a = PROD_W'(cos_reg[1]); op_b = PROD_W'(sin_reg[0]); end
            4'd4:    begin op_a = PROD_W'(cos_reg[2]); op_b = PROD_W'(sin_reg[0]); end
            4'd5:    begin op_a = pr_reg[0];           op_b = PROD_W'(cos_reg[0]); end
            4'd6:    begin op_a = PROD_W'(cos_reg[2]); op_b = PROD_W'(cos_reg[0]); end
            4'd7:    begin op_a = pr_reg[0];           op_b = PROD_W'(sin_reg[0]); end
            4'd8:    begin op_a = PROD_W'(sin_reg[2]); op_b = PROD_W'(cos_reg[1]); end
            4'd9:    begin op_a = PROD_W'(sin_reg[2]); op_b = PROD_W'(sin_reg[0]); end
            4'd10:   begin op_a = pr_reg[1];           op_b = PROD_W'(cos_reg[0]); end
            4'd11:   begin op_a = PROD_W'(sin_reg[2]); op_b = PROD_W'(cos_reg[0]); end
            4'd12:   begin op_a = pr_reg[1];           op_b = PROD_W'(sin_reg[0]); end
            4'd13:   begin op_a = PROD_W'(cos_reg[2]); op_b = PROD_W'(cos_reg[1]); end
            default: begin op_a = '0;                  op_b = '0;                  end
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            BLD_X:    begin mul_a = MUL_W'(oct);    mul_b = TWO_PI_Q30;     end
            BLD_X2:   begin mul_a = MUL_W'(x_reg);  mul_b = MUL_W'(x_reg);  end
            BLD_DIVM: begin mul_a = MUL_W'(v_reg);  mul_b = RECIP[k_reg];   end
            BLD_PMUL: begin mul_a = MUL_W'(x2_reg); mul_b = MUL_W'(t_reg);  end
            BLD_SFIN: begin mul_a = MUL_W'(x_reg);  mul_b = MUL_W'(t_reg);  end
            BLD_PROD: begin mul_a = MUL_W'(op_a);   mul_b = MUL_W'(op_b);   end
            default:  begin mul_a = '0;             mul_b = '0;             end
        endcase
    end

    assign prod_full = $signed(mul_a) * $signed(mul_b);
    assign prod_rnd  = prod_full + (2*MUL_W)'(1 << (TERM_FRAC_BITS - 1));
    assign pr_new    = prod_rnd[TERM_FRAC_BITS +: PROD_W];

    always_comb
    begin
        qd     = (Q_BITS+DIV_W)'(qe_reg) * (Q_BITS+DIV_W)'(DIVISOR[k_reg]);
        rem    = (Q_BITS+DIV_W)'(v_reg) - qd;
        q      = qe_reg + Q_BITS'(rem >= (Q_BITS+DIV_W)'(DIVISOR[k_reg]));
        t_new  = Q30_ONE - (Q_BITS+1)'(q);
        pc_new = q30_to_term(t_new);
        if (swap)
        begin
            s_oct = $signed(pc_new);
            c_oct = $signed(ps_reg);
        end
        else
        begin
            s_oct = $signed(ps_reg);
            c_oct = $signed(pc_new);
        end
        case (quad)
            2'd0:    begin s_fin = s_oct;  c_fin = c_oct;  end
            2'd1:    begin s_fin = c_oct;  c_fin = -s_oct; end
            2'd2:    begin s_fin = -s_oct; c_fin = -c_oct; end
            default: begin s_fin = -c_oct; c_fin = s_oct;  end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BLD_IDLE:
                if (cfg_fire && cfg_is_angle)
                    state_next = BLD_X;
            BLD_X:    state_next = BLD_X2;
            BLD_X2:   state_next = BLD_DIVM;
            BLD_DIVM: state_next = BLD_DIVF;
            BLD_DIVF:
                if (k_reg == SIN_LAST)
                    state_next = BLD_SFIN;
                else if (k_reg == COS_LAST)
                    state_next = (ai_reg == 2'd2) ? BLD_PROD : BLD_X;
                else
                    state_next = BLD_PMUL;
            BLD_PMUL: state_next = BLD_DIVM;
            BLD_SFIN: state_next = BLD_DIVM;
            BLD_PROD:
                if (pi_reg == PI_W'(NUM_PROD - 1))
                    state_next = BLD_COMB;
            BLD_COMB: state_next = BLD_IDLE;
            default:  state_next = BLD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BLD_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg[0] <= '0;
            angle_reg[1] <= '0;
            angle_reg[2] <= '0;
            ai_reg       <= '0;
            k_reg        <= '0;
            pi_reg       <= '0;
            terms_reg    <= TERM_IDENTITY;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg.index)
                    REG_ANGLE_Z: angle_reg[0] <= cfg.data;
                    REG_ANGLE_Y: angle_reg[1] <= cfg.data;
                    REG_ANGLE_X: angle_reg[2] <= cfg.data;
                    default: ;
                endcase
            end
            case (state_reg)
                BLD_IDLE: ai_reg <= '0;
                BLD_X2:   k_reg  <= '0;
                BLD_SFIN: k_reg  <= COS_FIRST;
                BLD_DIVF:
                begin
                    if (k_reg == COS_LAST)
                    begin
                        ai_reg <= ai_reg + 2'd1;
                        pi_reg <= '0;
                    end
                    else if (k_reg != SIN_LAST)
                        k_reg <= k_reg + K_W'(1);
                end
                BLD_PROD: pi_reg <= pi_reg + PI_W'(1);
                BLD_COMB:
                begin
                    terms_reg[0] <= clamp_term((PROD_W+1)'(pr_reg[2]));
                    terms_reg[1] <= clamp_term(-(PROD_W+1)'(pr_reg[3]));
                    terms_reg[2] <= clamp_term((PROD_W+1)'(sin_reg[1]));
                    terms_reg[3] <= clamp_term((PROD_W+1)'(pr_reg[4])
                                               + (PROD_W+1)'(pr_reg[5]));
                    terms_reg[4] <= clamp_term((PROD_W+1)'(pr_reg[6])
                                               - (PROD_W+1)'(pr_reg[7]));
                    terms_reg[5] <= clamp_term(-(PROD_W+1)'(pr_reg[8]));
                    terms_reg[6] <= clamp_term((PROD_W+1)'(pr_reg[9])
                                               - (PROD_W+1)'(pr_reg[10]));
                    terms_reg[7] <= clamp_term((PROD_W+1)'(pr_reg[11])
                                               + (PROD_W+1)'(pr_reg[12]));
                    terms_reg[8] <= clamp_term((PROD_W+1)'(pr_reg[13]));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BLD_X:    x_reg <= prod_full[ANGLE_W +: Q_BITS];
            BLD_X2:
            begin
                x2_reg <= prod_full[Q_BITS +: Q_BITS];
                v_reg  <= prod_full[Q_BITS +: Q_BITS];
            end
            BLD_DIVM: qe_reg <= prod_full[RECIP_SHIFT +: Q_BITS];
            BLD_DIVF:
            begin
                t_reg <= t_new;
                if (k_reg == COS_LAST)
                begin
                    sin_reg[ai_reg] <= s_fin;
                    cos_reg[ai_reg] <= c_fin;
                end
            end
            BLD_PMUL: v_reg <= prod_full[Q_BITS +: Q_BITS];
            BLD_SFIN:
            begin
                ps_reg <= q30_to_term(prod_full[Q_BITS +: Q_BITS+1]);
                v_reg  <= x2_reg;
            end
            BLD_PROD: pr_reg[pi_reg] <= pr_new;
            default: ;
        endcase
    end

endmodule

### rtl/erot_front.sv
// ---------------------------------------------------------------------------
// Point rotator front end
// Registers incoming points and holds them off while terms are rebuilt.
// ---------------------------------------------------------------------------
module erot_front import erot_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    erot_in_if.sink   in_pt,
    input  logic      busy,
    output logic      push_valid,
    input  logic      push_ready,
    output point_t    push_data
);

    logic   f_valid_reg, f_valid_next;
    point_t f_pt_reg;
    logic   take;

    assign in_pt.ready = !busy && (!f_valid_reg || push_ready);
    assign take        = in_pt.valid && in_pt.ready;
    assign push_valid  = f_valid_reg;
    assign push_data   = f_pt_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (take)
            f_valid_next = 1'b1;
        else if (push_ready)
            f_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_pt_reg.x <= in_pt.in_x;
            f_pt_reg.y <= in_pt.in_y;
            f_pt_reg.z <= in_pt.in_z;
        end
    end

endmodule

### rtl/erot_queue.sv
// ---------------------------------------------------------------------------
// Point rotator queue
// Short word queue between front end and rotation pipeline.
// ---------------------------------------------------------------------------
module erot_queue import erot_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  point_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output point_t pop_data
);

    point_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/erot_back.sv
// ---------------------------------------------------------------------------
// Point rotator back end
// Matrix multiply, round and saturate pipeline with output register.
// ---------------------------------------------------------------------------
module erot_back import erot_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  point_t     in_data,
    input  term_mat_t  terms,
    erot_out_if.source out_pt
);

    logic                        v1_reg;
    logic                        v2_reg;
    logic                        v3_reg;
    logic signed [PT_PROD_W-1:0] p1_reg [NUM_TERMS];
    logic signed [ACC_W-1:0]     acc2_reg [3];
    logic                        ready2;
    logic                        ready3;
    logic signed [COORD_W-1:0]   coord [3];
    logic signed [RND_W-1:0]     rv [3];
    logic signed [COORD_W-1:0]   sat_v [3];
    logic [2:0]                  clip;

    assign coord[0] = in_data.x;
    assign coord[1] = in_data.y;
    assign coord[2] = in_data.z;

    assign ready3   = !v3_reg || out_pt.ready;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = !v1_reg || ready2;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rv[i] = RND_W'((acc2_reg[i] + ACC_W'(1 << (TERM_FRAC_BITS - 1)))
                           >>> TERM_FRAC_BITS);
            if (rv[i] > RND_W'(COORD_MAX))
            begin
                sat_v[i] = COORD_MAX;
                clip[i]  = 1'b1;
            end
            else if (rv[i] < RND_W'(COORD_MIN))
            begin
                sat_v[i] = COORD_MIN;
                clip[i]  = 1'b1;
            end
            else
            begin
                sat_v[i] = COORD_W'(rv[i]);
                clip[i]  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
            if (ready3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    p1_reg[r*3+c] <= $signed(terms[r*3+c]) * coord[c];
                end
            end
        end
        if (v1_reg && ready2)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc2_reg[r] <= ACC_W'(p1_reg[r*3]) + ACC_W'(p1_reg[r*3+1])
                               + ACC_W'(p1_reg[r*3+2]);
            end
        end
        if (v2_reg && ready3)
        begin
            out_pt.out_x     <= sat_v[0];
            out_pt.out_y     <= sat_v[1];
            out_pt.out_z     <= sat_v[2];
            out_pt.saturated <= |clip;
        end
    end

    assign out_pt.valid = v3_reg;

endmodule

### rtl/euler_quaternion_point_rotate_core.sv
// ---------------------------------------------------------------------------
// Euler angle point rotator
// Rotates signed Q16.16 points about z, then y, then x.
// ---------------------------------------------------------------------------
// Takes one point per clock while no rebuild runs and the output is not
// stalled; a point passes the front register, queue, multiply stage, sum
// stage and output register. An angle write starts a rebuild of the nine
// matrix terms on one shared multiplier: sine and cosine by Taylor series
// for each angle, then fourteen term products; this holds input off until
// the rebuild ends. Outputs saturate to the 32-bit range and flag it.
module euler_quaternion_point_rotate_core import erot_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    erot_cfg_if.sink   cfg,
    erot_in_if.sink    in_pt,
    erot_out_if.source out_pt
);

`include "assert_macros.svh"

    logic      busy;
    term_mat_t terms;
    logic      f_valid;
    logic      f_ready;
    point_t    f_data;
    logic      b_valid;
    logic      b_ready;
    point_t    b_data;
    logic      cfg_angle_fire;
    logic      out_on_rail;

    erot_terms u_terms (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .busy  (busy),
        .terms (terms)
    );

    erot_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_pt      (in_pt),
        .busy       (busy),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data)
    );

    erot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    erot_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_data  (b_data),
        .terms    (terms),
        .out_pt   (out_pt)
    );

    assign cfg_angle_fire = cfg.valid && cfg.ready
                            && (cfg.index inside {REG_ANGLE_Z, REG_ANGLE_Y, REG_ANGLE_X});
    assign out_on_rail    = (out_pt.out_x == COORD_MAX) || (out_pt.out_x == COORD_MIN)
                            || (out_pt.out_y == COORD_MAX) || (out_pt.out_y == COORD_MIN)
                            || (out_pt.out_z == COORD_MAX) || (out_pt.out_z == COORD_MIN);

    `ASSERT_NEXT(a_cfg_holds_input, clk, rst_n, cfg_angle_fire, !in_pt.ready)
    `ASSERT_IMPLIES(a_busy_holds_input, clk, rst_n, busy, !in_pt.ready && !cfg.ready)
    `ASSERT_IMPLIES(a_sat_on_rail, clk, rst_n, out_pt.valid && out_pt.saturated, out_on_rail)

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Point rotator testbench
// Streams points through the rotator under several angle settings and
// random flow control. Every result word is checked against a built-in
// matrix predictor or a typed expectation. A directed table covers the
// field extremes, angle octant and quadrant edges, output clamping and
// writes to the unused register index. A random part follows.
// ---------------------------------------------------------------------------
module testbench;
    import erot_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         RAND_BATCHES = 13;
    localparam int         BATCH_ITEMS = 100;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      sat;
    } rot_result_t;

    typedef enum logic { ROW_CFG, ROW_POINT } row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [1:0]                idx;
        logic [ANGLE_W-1:0]        data;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        bit                        typed;
        rot_result_t               res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    erot_cfg_if cfg_ch();
    erot_in_if  pt_in();
    erot_out_if pt_out();

    euler_quaternion_point_rotate_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .in_pt  (pt_in.sink),
        .out_pt (pt_out.source)
    );

    logic [ANGLE_W-1:0] angle_reg [3];
    longint             rot_mat [9];
    rot_result_t        pending_points [$];
    int                 error_count;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 results_seen;
    int                 hold_left;
    bit                 hold_done;
    dir_row_t           dir_rows [$];

    function automatic longint round_term(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint term_mul(longint a, longint b);
        return round_term(a * b, TERM_FRAC_BITS);
    endfunction

    function automatic longint to_term(longint unsigned v);
        return longint'((v + (64'd1 << (29 - TERM_FRAC_BITS))) >> (30 - TERM_FRAC_BITS));
    endfunction

    task automatic octant_sin_cos(input longint unsigned a, output longint s,
                                  output longint c);
        longint unsigned one, x, x2, t;
        one = 64'd1 << 30;
        x   = (a * 64'd6746518852) >> 16;
        x2  = (x * x) >> 30;
        t = one - x2 / 42;
        t = one - ((x2 * t) >> 30) / 20;
        t = one - ((x2 * t) >> 30) / 6;
        s = to_term((x * t) >> 30);
        t = one - x2 / 56;
        t = one - ((x2 * t) >> 30) / 30;
        t = one - ((x2 * t) >> 30) / 12;
        t = one - ((x2 * t) >> 30) / 2;
        c = to_term(t);
    endtask

    task automatic angle_sin_cos(input logic [ANGLE_W-1:0] ang, output longint s,
                                 output longint c);
        logic [1:0]  quad;
        logic [13:0] r;
        longint      ps, pc;
        quad = ang[15:14];
        r    = ang[13:0];
        if (r <= 14'd8192)
            octant_sin_cos(r, ps, pc);
        else
            octant_sin_cos(16384 - r, pc, ps);
        case (quad)
            2'd0: begin s = ps;  c = pc;  end
            2'd1: begin s = pc;  c = -ps; end
            2'd2: begin s = -ps; c = -pc; end
            default: begin s = -pc; c = ps; end
        endcase
    endtask

    function automatic longint clamp_unit(longint v);
        if (v > TERM_ONE)
            return TERM_ONE;
        if (v < -TERM_ONE)
            return -TERM_ONE;
        return v;
    endfunction

    task automatic rebuild_matrix();
        longint sz, cz, sy, cy, sx, cx, sxsy, cxsy;
        angle_sin_cos(angle_reg[REG_ANGLE_Z], sz, cz);
        angle_sin_cos(angle_reg[REG_ANGLE_Y], sy, cy);
        angle_sin_cos(angle_reg[REG_ANGLE_X], sx, cx);
        sxsy = term_mul(sx, sy);
        cxsy = term_mul(cx, sy);
        rot_mat[0] = clamp_unit(term_mul(cy, cz));
        rot_mat[1] = clamp_unit(-term_mul(cy, sz));
        rot_mat[2] = clamp_unit(sy);
        rot_mat[3] = clamp_unit(term_mul(cx, sz) + term_mul(sxsy, cz));
        rot_mat[4] = clamp_unit(term_mul(cx, cz) - term_mul(sxsy, sz));
        rot_mat[5] = clamp_unit(-term_mul(sx, cy));
        rot_mat[6] = clamp_unit(term_mul(sx, sz) - term_mul(cxsy, cz));
        rot_mat[7] = clamp_unit(term_mul(sx, cz) + term_mul(cxsy, sz));
        rot_mat[8] = clamp_unit(term_mul(cx, cy));
    endtask

    function automatic rot_result_t rotate_point(logic signed [COORD_W-1:0] px,
                                                 logic signed [COORD_W-1:0] py,
                                                 logic signed [COORD_W-1:0] pz);
        rot_result_t r;
        longint      v [3];
        r.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = round_term(rot_mat[3*i] * longint'(px) + rot_mat[3*i+1] * longint'(py)
                              + rot_mat[3*i+2] * longint'(pz), TERM_FRAC_BITS);
            if (v[i] > longint'(COORD_MAX))
            begin
                v[i] = COORD_MAX;
                r.sat = 1'b1;
            end
            if (v[i] < longint'(COORD_MIN))
            begin
                v[i] = COORD_MIN;
                r.sat = 1'b1;
            end
        end
        r.x = v[0][31:0];
        r.y = v[1][31:0];
        r.z = v[2][31:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial
    begin
        pt_out.ready = 1'b0;
        hold_left    = 0;
        hold_done    = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pt_out.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            pt_out.ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 400)
        begin
            hold_done    <= 1'b1;
            hold_left    <= 300;
            pt_out.ready <= 1'b0;
        end
        else
            pt_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(negedge clk)
    begin
        rot_result_t exp_res;
        if (rst_n && pt_out.valid && pt_out.ready)
        begin
            results_seen++;
            if (pending_points.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word x=%h y=%h z=%h sat=%b", $time,
                         pt_out.out_x, pt_out.out_y, pt_out.out_z, pt_out.saturated);
            end
            else
            begin
                exp_res = pending_points.pop_front();
                if (pt_out.out_x !== exp_res.x || pt_out.out_y !== exp_res.y ||
                    pt_out.out_z !== exp_res.z || pt_out.saturated !== exp_res.sat)
                begin
                    error_count++;
                    $display("%0t: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                             $time, exp_res.x, exp_res.y, exp_res.z, exp_res.sat,
                             pt_out.out_x, pt_out.out_y, pt_out.out_z, pt_out.saturated);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_angle(logic [1:0] idx, logic [ANGLE_W-1:0] data);
        bit ok;
        pt_in.valid <= 1'b0;
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
        begin
            @(negedge clk);
            ok = cfg_ch.ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_ch.valid <= 1'b0;
        if (idx != REG_UNUSED)
        begin
            angle_reg[idx] = data;
            rebuild_matrix();
        end
    endtask

    task automatic send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                              logic signed [COORD_W-1:0] pz, bit typed, rot_result_t res);
        bit ok;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pt_in.valid <= 1'b0;
            @(posedge clk);
        end
        pt_in.valid <= 1'b1;
        pt_in.in_x  <= px;
        pt_in.in_y  <= py;
        pt_in.in_z  <= pz;
        do
        begin
            @(negedge clk);
            ok = pt_in.ready;
            if (ok)
                pending_points.push_back(typed ? res : rotate_point(px, py, pz));
            @(posedge clk);
        end
        while (!ok);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
            1, 2: return $urandom;
            default: return 32'($signed($urandom_range(2097151)) - 1048576);
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] random_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(8) * 8192 + $urandom_range(2) - 1);
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic dir_row_t cfg_row(logic [1:0] idx, logic [ANGLE_W-1:0] data);
        dir_row_t r;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.data  = data;
        r.x     = '0;
        r.y     = '0;
        r.z     = '0;
        r.typed = 1'b0;
        r.res   = '{0, 0, 0, 0};
        return r;
    endfunction

    function automatic dir_row_t pt_row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                        bit typed, logic [31:0] ex, logic [31:0] ey,
                                        logic [31:0] ez, logic es);
        dir_row_t r;
        r.kind  = ROW_POINT;
        r.idx   = '0;
        r.data  = '0;
        r.x     = px;
        r.y     = py;
        r.z     = pz;
        r.typed = typed;
        r.res   = '{ex, ey, ez, es};
        return r;
    endfunction

    initial
    begin
        rot_result_t none;
        none           = '{0, 0, 0, 0};
        error_count    = 0;
        results_seen   = 0;
        send_idle_pct  = 13;
        recv_stall_pct = 62;
        rst_n          = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_ANGLE_Z;
        cfg_ch.data    = '0;
        pt_in.valid    = 1'b0;
        pt_in.in_x     = '0;
        pt_in.in_y     = '0;
        pt_in.in_z     = '0;
        for (int i = 0; i < 3; i++)
            angle_reg[i] = '0;
        rebuild_matrix();

        dir_rows.push_back(pt_row(0, 0, 0, 1, 0, 0, 0, 0));
        dir_rows.push_back(pt_row(COORD_MAX, COORD_MIN, 1, 1, COORD_MAX, COORD_MIN, 1, 0));
        dir_rows.push_back(pt_row(COORD_MIN, COORD_MAX, -1, 1, COORD_MIN, COORD_MAX, -1, 0));
        dir_rows.push_back(pt_row(1, -1, 32'h10000, 1, 1, -1, 32'h10000, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_Z, 16'd16384));
        dir_rows.push_back(pt_row(COORD_MIN, COORD_MIN, 5, 1, COORD_MAX, COORD_MIN, 5, 1));
        dir_rows.push_back(cfg_row(REG_UNUSED, 16'hFFFF));
        dir_rows.push_back(pt_row(7, COORD_MAX, 3, 1, -32'sh7FFF_FFFF, 7, 3, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_Z, 16'd0));
        dir_rows.push_back(cfg_row(REG_ANGLE_Y, 16'd32768));
        dir_rows.push_back(pt_row(32'h12345, -32'h6789A, COORD_MAX, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_X, 16'hFFFF));
        dir_rows.push_back(pt_row(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_Y, 16'd8192));
        dir_rows.push_back(pt_row(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_Y, 16'd8193));
        dir_rows.push_back(pt_row(32'h10000, 32'h20000, -32'h30000, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_X, 16'd49152));
        dir_rows.push_back(pt_row(COORD_MAX, 0, COORD_MIN, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_ANGLE_Z, 16'hFFFF));
        dir_rows.push_back(pt_row(-1, 1, -32'h8000, 0, 0, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_angle(dir_rows[i].idx, dir_rows[i].data);
            else
                send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                           dir_rows[i].typed, dir_rows[i].res);
        end
        pt_in.valid <= 1'b0;

        for (int b = 0; b < RAND_BATCHES; b++)
        begin
            if (b == 5)
            begin
                send_idle_pct  = 62;
                recv_stall_pct = 13;
            end
            else if (b == 10)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_angle(REG_ANGLE_Z, random_angle());
            if ($urandom_range(3) != 0)
                write_angle(REG_ANGLE_Y, random_angle());
            if ($urandom_range(3) != 0)
                write_angle(REG_ANGLE_X, random_angle());
            if ($urandom_range(7) == 0)
                write_angle(REG_UNUSED, 16'($urandom_range(65535)));
            for (int n = 0; n < BATCH_ITEMS; n++)
                send_point(random_coord(), random_coord(), random_coord(), 0, none);
            pt_in.valid <= 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/erot_pkg.sv
rtl/erot_if.sv
rtl/erot_terms.sv
rtl/erot_front.sv
rtl/erot_queue.sv
rtl/erot_back.sv
rtl/euler_quaternion_point_rotate_core.sv
tb/testbench.sv
